@@ rtl/selective_repeat_sender_unit_macros.svh @@
// Assertion macros for the selective-repeat sender unit.
// Used by the top level; relies on signals named clock and reset in the including scope.
`ifndef SELECTIVE_REPEAT_SENDER_UNIT_MACROS_SVH
`define SELECTIVE_REPEAT_SENDER_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SRS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SRS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/srs_pkg.sv @@
// Shared types, constants and the microcode table of the selective-repeat sender.
// No dependencies; imported by the sequencer, the datapath and the top level.
package srs_pkg;

   localparam int MAX_PACKETS = 64;
   localparam int PKT_W       = $clog2(MAX_PACKETS);
   localparam int NUM_W       = PKT_W + 1;
   localparam int STEP_W      = 4;

   localparam logic [NUM_W-1:0] TOTAL_RESET  = NUM_W'(5);
   localparam logic [NUM_W-1:0] WINDOW_RESET = NUM_W'(2);
   localparam logic [NUM_W-1:0] MAX_NUM      = NUM_W'(MAX_PACKETS);

   typedef enum logic [1:0] {
      ACT_START   = 2'd0,
      ACT_TIMEOUT = 2'd1,
      ACT_ACK     = 2'd2,
      ACT_NACK    = 2'd3
   } action_type;

   typedef enum logic {
      CSR_TOTAL  = 1'b0,
      CSR_WINDOW = 1'b1
   } csr_index_type;

   typedef struct packed {
      action_type       action;
      logic [NUM_W-1:0] seq_num;
   } req_word_type;

   typedef struct packed {
      logic [PKT_W-1:0] packet_number;
      logic             last_of_run;
      logic             all_acked;
   } rsp_word_type;

   typedef enum logic [2:0] {
      UOP_NOP,
      UOP_NACK,
      UOP_SCAN_INIT,
      UOP_SCAN,
      UOP_FLUSH,
      UOP_SET_MARK,
      UOP_SLIDE,
      UOP_EMIT_LIMIT
   } uop_type;

   typedef enum logic [3:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_DONE,
      COND_IS_SEND,
      COND_ID_BAD,
      COND_IS_ACK,
      COND_SCAN_MORE,
      COND_SLIDE_MORE,
      COND_CNT_MULTI
   } cond_type;

   typedef struct packed {
      uop_type           uop;
      cond_type          cond;
      logic [STEP_W-1:0] target;
   } ucode_word_type;

   // Status flags from the datapath that the sequencer branches on.
   typedef struct packed {
      logic done;
      logic is_send;
      logic id_bad;
      logic is_ack;
      logic scan_more;
      logic slide_more;
      logic cnt_multi;
   } dp_status_type;

   // Per-cycle control from the sequencer to the datapath.
   typedef struct packed {
      logic    accept;
      uop_type uop;
   } dp_ctrl_type;

   localparam logic [STEP_W-1:0] S_IDLE      = STEP_W'(0);
   localparam logic [STEP_W-1:0] S_CHK_DONE  = STEP_W'(1);
   localparam logic [STEP_W-1:0] S_CHK_SEND  = STEP_W'(2);
   localparam logic [STEP_W-1:0] S_CHK_ID    = STEP_W'(3);
   localparam logic [STEP_W-1:0] S_CHK_ACK   = STEP_W'(4);
   localparam logic [STEP_W-1:0] S_NACK      = STEP_W'(5);
   localparam logic [STEP_W-1:0] S_SCAN_INIT = STEP_W'(6);
   localparam logic [STEP_W-1:0] S_SCAN      = STEP_W'(7);
   localparam logic [STEP_W-1:0] S_FLUSH     = STEP_W'(8);
   localparam logic [STEP_W-1:0] S_SET_MARK  = STEP_W'(9);
   localparam logic [STEP_W-1:0] S_SLIDE     = STEP_W'(10);
   localparam logic [STEP_W-1:0] S_EMIT      = STEP_W'(11);
   localparam logic [STEP_W-1:0] S_RETURN    = STEP_W'(12);

   // Microcode ROM. A step runs its operation and then jumps to target when its
   // condition holds, otherwise it falls through to the next step.
   function automatic ucode_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_word_type w;
      begin
         case (step)
            S_IDLE:      w = '{UOP_NOP,        COND_NEVER,      S_IDLE};
            S_CHK_DONE:  w = '{UOP_NOP,        COND_DONE,       S_IDLE};
            S_CHK_SEND:  w = '{UOP_NOP,        COND_IS_SEND,    S_SCAN_INIT};
            S_CHK_ID:    w = '{UOP_NOP,        COND_ID_BAD,     S_IDLE};
            S_CHK_ACK:   w = '{UOP_NOP,        COND_IS_ACK,     S_SET_MARK};
            S_NACK:      w = '{UOP_NACK,       COND_ALWAYS,     S_IDLE};
            S_SCAN_INIT: w = '{UOP_SCAN_INIT,  COND_NEVER,      S_IDLE};
            S_SCAN:      w = '{UOP_SCAN,       COND_SCAN_MORE,  S_SCAN};
            S_FLUSH:     w = '{UOP_FLUSH,      COND_ALWAYS,     S_IDLE};
            S_SET_MARK:  w = '{UOP_SET_MARK,   COND_NEVER,      S_IDLE};
            S_SLIDE:     w = '{UOP_SLIDE,      COND_SLIDE_MORE, S_SLIDE};
            S_EMIT:      w = '{UOP_EMIT_LIMIT, COND_CNT_MULTI,  S_EMIT};
            S_RETURN:    w = '{UOP_NOP,        COND_ALWAYS,     S_IDLE};
            default:     w = '{UOP_NOP,        COND_ALWAYS,     S_IDLE};
         endcase
         return w;
      end
   endfunction

endpackage

@@ rtl/srs_sequencer.sv @@
// Microcode sequencer of the selective-repeat sender: step counter and branch logic.
// Depends on srs_pkg for the control word layout and the microcode ROM.
module srs_sequencer
   import srs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type status,
   output logic          busy,
   output dp_ctrl_type   ctrl
);

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   ucode_word_type    word;
   logic              take;

   always_comb begin
      word = ucode_rom(step_ff);
      case (word.cond)
         COND_NEVER:      take = 1'b0;
         COND_ALWAYS:     take = 1'b1;
         COND_DONE:       take = status.done;
         COND_IS_SEND:    take = status.is_send;
         COND_ID_BAD:     take = status.id_bad;
         COND_IS_ACK:     take = status.is_ack;
         COND_SCAN_MORE:  take = status.scan_more;
         COND_SLIDE_MORE: take = status.slide_more;
         COND_CNT_MULTI:  take = status.cnt_multi;
         default:         take = 1'b0;
      endcase
   end

   always_comb begin
      busy = (step_ff != S_IDLE);
      if (!busy) begin
         // The idle step waits for a command word.
         ctrl.accept = start;
         ctrl.uop    = UOP_NOP;
         step_in     = start ? S_CHK_DONE : S_IDLE;
      end else begin
         ctrl.accept = 1'b0;
         ctrl.uop    = word.uop;
         step_in     = take ? word.target : step_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

@@ rtl/srs_datapath.sv @@
// Datapath of the selective-repeat sender: ack bitmap, window pointers, scan pointer,
// send counter, one-deep hold register and the result register. Depends on srs_pkg.
module srs_datapath
   import srs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dp_ctrl_type   ctrl,
   input  req_word_type  req_word,
   input  logic          csr_write,
   input  csr_index_type csr_index,
   input  logic [NUM_W-1:0] csr_data,
   output dp_status_type status,
   output logic          rsp_valid,
   output rsp_word_type  rsp_word
);

   logic [NUM_W-1:0]       total_ff;
   logic [NUM_W-1:0]       first_ff;
   logic [NUM_W-1:0]       limit_ff;
   logic [MAX_PACKETS-1:0] marks_ff;
   action_type             action_ff;
   logic [NUM_W-1:0]       id_ff;
   logic [NUM_W-1:0]       idx_ff;
   logic [NUM_W-1:0]       cnt_ff;
   logic [PKT_W-1:0]       pend_ff;
   logic                   pend_valid_ff;
   logic                   rsp_valid_ff;
   rsp_word_type           rsp_word_ff;

   logic [NUM_W-1:0] total_eff;
   logic [NUM_W-1:0] stop;
   logic [NUM_W:0]   ahead;
   logic             idx_marked;
   logic             first_marked;

   always_comb begin
      total_eff    = (total_ff > MAX_NUM) ? MAX_NUM : total_ff;
      stop         = (limit_ff < total_eff) ? limit_ff : total_eff;
      ahead        = {1'b0, limit_ff} + {1'b0, cnt_ff};
      idx_marked   = marks_ff[idx_ff[PKT_W-1:0]];
      first_marked = marks_ff[first_ff[PKT_W-1:0]];

      status.done       = (first_ff >= total_eff);
      status.is_send    = (action_ff == ACT_START) || (action_ff == ACT_TIMEOUT);
      status.id_bad     = (id_ff >= total_eff);
      status.is_ack     = (action_ff == ACT_ACK);
      status.scan_more  = (idx_ff < stop);
      status.slide_more = (first_ff < total_eff) && first_marked;
      status.cnt_multi  = (cnt_ff > NUM_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff      <= TOTAL_RESET;
         first_ff      <= '0;
         limit_ff      <= WINDOW_RESET;
         marks_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;

         if (csr_write) begin
            case (csr_index)
               CSR_TOTAL:  total_ff <= csr_data;
               CSR_WINDOW: limit_ff <= (csr_data > MAX_NUM) ? MAX_NUM : csr_data;
               default:    total_ff <= total_ff;
            endcase
         end

         if (ctrl.accept) begin
            action_ff <= req_word.action;
            id_ff     <= req_word.seq_num;
            cnt_ff    <= '0;
         end

         case (ctrl.uop)
            UOP_NACK: begin
               marks_ff[id_ff[PKT_W-1:0]] <= 1'b0;
               rsp_valid_ff               <= 1'b1;
               rsp_word_ff                <= '{id_ff[PKT_W-1:0], 1'b1, 1'b0};
            end
            UOP_SCAN_INIT: begin
               idx_ff        <= first_ff;
               pend_valid_ff <= 1'b0;
            end
            UOP_SCAN: begin
               if (status.scan_more) begin
                  idx_ff <= idx_ff + NUM_W'(1);
                  if (!idx_marked) begin
                     // Hold the newest send back one find so the final one can be marked.
                     if (pend_valid_ff) begin
                        rsp_valid_ff <= 1'b1;
                        rsp_word_ff  <= '{pend_ff, 1'b0, 1'b0};
                     end
                     pend_ff       <= idx_ff[PKT_W-1:0];
                     pend_valid_ff <= 1'b1;
                  end
               end
            end
            UOP_FLUSH: begin
               if (pend_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_word_ff  <= '{pend_ff, 1'b1, 1'b0};
               end
               pend_valid_ff <= 1'b0;
            end
            UOP_SET_MARK: begin
               marks_ff[id_ff[PKT_W-1:0]] <= 1'b1;
            end
            UOP_SLIDE: begin
               if (status.slide_more) begin
                  first_ff <= first_ff + NUM_W'(1);
                  if (ahead < {1'b0, total_eff}) begin
                     cnt_ff <= cnt_ff + NUM_W'(1);
                  end
               end
            end
            UOP_EMIT_LIMIT: begin
               if (cnt_ff != '0) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_word_ff  <= '{limit_ff[PKT_W-1:0], !status.cnt_multi, status.done};
                  limit_ff     <= limit_ff + NUM_W'(1);
                  cnt_ff       <= cnt_ff - NUM_W'(1);
               end
            end
            default: begin
               pend_valid_ff <= pend_valid_ff;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

@@ rtl/selective_repeat_sender_unit.sv @@
// Top level of the selective-repeat sender: sequencer plus datapath, ports and checks.
// Depends on srs_pkg, srs_sequencer, srs_datapath and selective_repeat_sender_unit_macros.svh.
//
// This unit is the control half of a selective-repeat ARQ sender. Each command word
// (start, timeout, ack or nack with a packet number) is taken when start is high and
// busy is low, and it produces zero or more send words, one per cycle at most, each
// shown on rsp_word for exactly one cycle with rsp_valid high. The receiver cannot
// stall this stream, so it must take every word in the cycle it appears. The last
// send word of a command carries last_of_run, and all_acked is set on every send word
// of a command that leaves the window start at the transfer total. Commands that send
// nothing (finished transfer, packet number out of range) give no word at all.
// Busy stays high while one microcode step a cycle walks the command: a nack checks
// the transfer, the command kind and the packet number, then clears its mark and sends;
// a start or timeout walks a single scan pointer over every window slot, then flushes
// the held send; an ack sets its mark, slides the window start over acknowledged
// packets and then sends from the window end, since the slide is counted first and the
// sends follow. Configuration writes are taken whenever busy is low; a window size
// write also reloads the window end.
`include "selective_repeat_sender_unit_macros.svh"

module selective_repeat_sender_unit
   import srs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_word_type     req_word,
   output logic             rsp_valid,
   output rsp_word_type     rsp_word,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  csr_index_type    csr_index,
   input  logic [NUM_W-1:0] csr_data
);

   dp_status_type status;
   dp_ctrl_type   ctrl;

   // Configuration is only taken between commands.
   assign csr_ready = !busy;

   srs_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .ctrl   (ctrl)
   );

   srs_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .req_word  (req_word),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   // A send word only follows a cycle in which a command was being worked.
   `SRS_ASSERT_NOW(a_rsp_from_work, rsp_valid, $past(busy), "send word without a command")
   // An accepted command always occupies the sequencer in the next cycle.
   `SRS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted command left no work")
   // A register write never lands while a command is in flight.
   `SRS_ASSERT_NOW(a_csr_idle, csr_valid && csr_ready, !busy, "register write while busy")

endmodule

@@ tb/sv/srs_send_checker.sv @@
// Send-stream checker for the selective-repeat sender unit.
// Depends on srs_pkg; watches the command, send and register channels of the unit.
module srs_send_checker
   import srs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  req_word_type     req_word,
   input  logic             rsp_valid,
   input  rsp_word_type     rsp_word,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  csr_index_type    csr_index,
   input  logic [NUM_W-1:0] csr_data,
   output int               mismatch_count,
   output int               expected_left,
   output logic [NUM_W-1:0] window_first_now,
   output logic [NUM_W-1:0] window_limit_now
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   logic [MAX_PACKETS-1:0] ack_marks;
   logic [NUM_W-1:0]       win_first;
   logic [NUM_W-1:0]       win_limit;
   logic [NUM_W-1:0]       total_reg;
   rsp_word_type           expected_sends[$];
   int                     errors = 0;

   function automatic logic [NUM_W-1:0] clamp_count(input logic [NUM_W-1:0] v);
      return (v > MAX_NUM) ? MAX_NUM : v;
   endfunction

   function automatic logic is_acked(input logic [NUM_W-1:0] i);
      return (i < MAX_NUM) && ack_marks[i[PKT_W-1:0]];
   endfunction

   // Updates the sender state for one command word and queues the packets it sends.
   task automatic predict_sends(input req_word_type w);
      logic [NUM_W-1:0] total;
      logic [NUM_W-1:0] stop;
      logic [NUM_W-1:0] i;
      logic [PKT_W-1:0] sends[$];
      logic             done;
      total = clamp_count(total_reg);
      if (win_first >= total) return;
      case (w.action)
         ACT_START, ACT_TIMEOUT: begin
            stop = (win_limit < total) ? win_limit : total;
            for (i = win_first; i < stop; i++) begin
               if (!is_acked(i)) sends.push_back(i[PKT_W-1:0]);
            end
         end
         ACT_NACK: begin
            if (w.seq_num >= total) return;
            ack_marks[w.seq_num[PKT_W-1:0]] = 1'b0;
            sends.push_back(w.seq_num[PKT_W-1:0]);
         end
         ACT_ACK: begin
            if (w.seq_num >= total) return;
            ack_marks[w.seq_num[PKT_W-1:0]] = 1'b1;
            while (win_first < total && is_acked(win_first)) begin
               win_first++;
               if (win_limit < total) begin
                  sends.push_back(win_limit[PKT_W-1:0]);
                  win_limit++;
               end
            end
         end
         default: ;
      endcase
      done = (win_first >= total);
      foreach (sends[k]) begin
         expected_sends.push_back('{packet_number: sends[k],
                                    last_of_run: (k == sends.size() - 1),
                                    all_acked: done});
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         ack_marks = '0;
         win_first = '0;
         total_reg = TOTAL_RESET;
         win_limit = clamp_count(WINDOW_RESET);
         expected_sends.delete();
      end else begin
         // Sends are checked before the command of the same edge is predicted.
         if (rsp_valid) begin
            if (expected_sends.size() == 0) begin
               if (errors < REPORT_LIMIT)
                  $display("unexpected send word: pkt %0d last %0b done %0b",
                           rsp_word.packet_number, rsp_word.last_of_run,
                           rsp_word.all_acked);
               errors++;
            end else begin
               rsp_word_type want;
               want = expected_sends.pop_front();
               if (rsp_word !== want) begin
                  if (errors < REPORT_LIMIT)
                     $display("send word wrong: expected pkt %0d last %0b done %0b, %s",
                              want.packet_number, want.last_of_run, want.all_acked,
                              $sformatf("got pkt %0d last %0b done %0b",
                                        rsp_word.packet_number, rsp_word.last_of_run,
                                        rsp_word.all_acked));
                  errors++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TOTAL:  total_reg = csr_data;
               CSR_WINDOW: win_limit = clamp_count(csr_data);
               default: ;
            endcase
         end
         if (start && !busy) predict_sends(req_word);
      end
      mismatch_count   <= errors;
      expected_left    <= expected_sends.size();
      window_first_now <= win_first;
      window_limit_now <= win_limit;
   end

endmodule

@@ tb/sv/tb_top.sv @@
// Top of the selective-repeat sender testbench: clock, reset, stimulus and verdict.
// Depends on srs_pkg, the selective_repeat_sender_unit RTL and srs_send_checker.
module tb_top;
   import srs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // The quiet time allowed before the registers are touched covers the longest
   // command, and the stall watchdog is set well above the longest legitimate
   // stretch without any accepted word.
   localparam int QUIET_CYCLES    = 150;
   localparam int STALL_LIMIT     = 4000;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 44;
   localparam int MAX_ID          = 127;

   logic             clock;
   logic             reset     = 1'b1;
   logic             start     = 1'b0;
   logic             busy;
   req_word_type     req_word  = '0;
   logic             rsp_valid;
   rsp_word_type     rsp_word;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   csr_index_type    csr_index = CSR_TOTAL;
   logic [NUM_W-1:0] csr_data  = '0;

   int               mismatch_count;
   int               expected_left;
   logic [NUM_W-1:0] window_first_now;
   logic [NUM_W-1:0] window_limit_now;
   int               stall_cycles = 0;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   selective_repeat_sender_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   srs_send_checker send_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_word         (rsp_word),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .mismatch_count   (mismatch_count),
      .expected_left    (expected_left),
      .window_first_now (window_first_now),
      .window_limit_now (window_limit_now)
   );

   // The watchdog counts cycles in which no command word, send word or register
   // write is accepted. A unit that hangs, or that drops a send the checker still
   // waits for, ends the run here.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Presents one command word and holds it until the unit takes it. The task
   // returns on the accepting edge with start still high, so a following command
   // can be presented back to back without start ever dropping.
   task automatic send_cmd(input action_type act, input logic [NUM_W-1:0] id);
      start    <= 1'b1;
      req_word <= '{action: act, seq_num: id};
      do @(posedge clock); while (busy);
   endtask

   // Drops start, waits until the checker holds no expected send and the unit is
   // idle, then lets the longest command time pass, since a command that sends
   // nothing gives no word to wait for.
   task automatic wait_quiet();
      start <= 1'b0;
      do @(posedge clock); while (expected_left != 0 || busy);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // Register writes only ever happen with the unit idle and nothing outstanding.
   task automatic write_csr(input csr_index_type idx, input logic [NUM_W-1:0] data);
      wait_quiet();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int         p;
      int         n;
      int         first;
      int         span;
      int         pick;
      int         id;
      int         win_data;
      action_type act;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part. It starts from the reset settings: five packets in the
      // transfer and a window end of two.
      send_cmd(ACT_START, 7'd0);     // sends packets 0 and 1
      send_cmd(ACT_TIMEOUT, 7'd0);   // the same two again
      send_cmd(ACT_NACK, 7'd1);      // nack inside the window
      send_cmd(ACT_NACK, 7'd4);      // nack beyond the window but below the total
      send_cmd(ACT_NACK, 7'd5);      // packet id equal to the total is ignored
      send_cmd(ACT_ACK, 7'(MAX_ID)); // largest packet id, ignored
      send_cmd(ACT_ACK, 7'd1);       // out of order ack, marks only
      send_cmd(ACT_START, 7'd0);     // skips the acknowledged packet
      send_cmd(ACT_ACK, 7'd0);       // slides over two packets and sends two more
      send_cmd(ACT_ACK, 7'd3);
      send_cmd(ACT_ACK, 7'd2);       // sends stop once the window end meets the total
      send_cmd(ACT_ACK, 7'd4);       // completes the transfer without sending anything
      send_cmd(ACT_START, 7'd0);     // completed transfer ignores every command

      // A total of zero counts as a completed transfer.
      write_csr(CSR_TOTAL, 7'd0);
      send_cmd(ACT_TIMEOUT, 7'd0);

      // Total and window size above the packet limit are both clamped to it, so
      // the next start walks the whole remaining window.
      write_csr(CSR_TOTAL, 7'(MAX_ID));
      write_csr(CSR_WINDOW, 7'(MAX_ID));
      send_cmd(ACT_START, 7'd0);
      send_cmd(ACT_NACK, 7'(MAX_PACKETS - 1));
      send_cmd(ACT_ACK, 7'(MAX_PACKETS));   // at the clamped total, ignored

      // A window end of zero lies below the window start: start sends nothing, but
      // a slide still sends from the window end.
      write_csr(CSR_WINDOW, 7'd0);
      send_cmd(ACT_START, 7'd0);
      send_cmd(ACT_ACK, 7'd5);
      write_csr(CSR_WINDOW, 7'd1);
      send_cmd(ACT_TIMEOUT, 7'd0);

      // Window start already at the new total: ignored.
      write_csr(CSR_TOTAL, 7'd6);
      send_cmd(ACT_ACK, 7'd2);

      // The final slide both sends a packet and completes the transfer, so the
      // done flag shows on a send word.
      write_csr(CSR_TOTAL, 7'd8);
      write_csr(CSR_WINDOW, 7'd7);
      send_cmd(ACT_ACK, 7'd7);
      send_cmd(ACT_ACK, 7'd6);
      send_cmd(ACT_NACK, 7'd0);

      // Random part. The window start only ever moves forward, so each phase
      // raises the total and reloads the window end, in most phases just past the
      // current start. Most commands are acks and nacks aimed at the live window;
      // the rest are noise over the full field ranges.
      for (p = 0; p < PHASES; p++) begin
         write_csr(CSR_TOTAL, (p == PHASES - 1) ? 7'd100 : 7'(16 + 8 * p));
         first = window_first_now;
         if (p == 1) begin
            win_data = first + MAX_PACKETS;
         end else if (p == PHASES - 1) begin
            win_data = MAX_ID;
         end else begin
            win_data = first + $urandom_range(1, 12);
         end
         if (win_data > MAX_ID) win_data = MAX_ID;
         write_csr(CSR_WINDOW, 7'(win_data));

         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Phase three runs with no gaps at all; elsewhere the sender pauses
            // at random, so that gaps land at every point of a busy command.
            if (p != 3 && $urandom_range(99) < 15) begin
               start <= 1'b0;
               repeat ($urandom_range(1, 40)) @(posedge clock);
            end
            // Once in the run the sender holds off until every send has come.
            if (p == 1 && n == ITEMS_PER_PHASE / 2) wait_quiet();

            first = window_first_now;
            span  = (window_limit_now > window_first_now) ?
                    window_limit_now - window_first_now : 1;
            pick  = $urandom_range(99);
            if (pick < 15) begin
               act = action_type'($urandom_range(3));
               id  = $urandom_range(MAX_ID);
            end else if (pick < 50) begin
               act = ACT_ACK;
               id  = ($urandom_range(99) < 20) ? first : first + $urandom_range(span + 1);
            end else if (pick < 70) begin
               act = ACT_NACK;
               id  = ($urandom_range(99) < 10) ? $urandom_range(first) :
                     first + $urandom_range(span);
            end else if (pick < 85) begin
               act = ACT_START;
               id  = $urandom_range(MAX_ID);
            end else begin
               act = ACT_TIMEOUT;
               id  = $urandom_range(MAX_ID);
            end
            if (id > MAX_ID) id = MAX_ID;
            send_cmd(act, 7'(id));
         end
      end

      wait_quiet();
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
